FILE: rtl/ptd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, constants and the control store of the pressure trend event
// detector.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int SQ_W        = 2 * SAMPLE_W;
  localparam int OFFSET_W    = 23;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 3;

  localparam logic signed [SAMPLE_W-1:0] REF_LEVEL_RESET  = '0;
  localparam logic [OFFSET_W-1:0]        MIN_OFFSET_RESET = 23'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFERENCE_LEVEL = 1'b0,
    REG_MIN_OFFSET      = 1'b1
  } cfg_reg_e;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_CHK   = 3'd1;
  localparam step_t ST_LOOP  = 3'd2;
  localparam step_t ST_SDIFF = 3'd3;
  localparam step_t ST_SQR   = 3'd4;
  localparam step_t ST_LHS   = 3'd5;
  localparam step_t ST_RHS   = 3'd6;
  localparam step_t ST_EMIT  = 3'd7;

  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_NO_IN     = 3'd1,
    COND_NOT_READY = 3'd2,
    COND_BUSY      = 3'd3,
    COND_OUT_FULL  = 3'd4
  } cond_e;

  typedef struct packed {
    logic  take;
    logic  run;
    logic  sdiff;
    logic  sqr;
    logic  scale_lhs;
    logic  scale_rhs;
    logic  emit;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic ready;
    logic busy;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic launch;
    logic apogee;
    logic window_ready;
  } res_t;

  // control store: one word per step, the step after the last wraps to idle
  function automatic ctrl_t mc_rom(input step_t pc);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_NEXT;
    w.target = ST_IDLE;
    unique case (pc)
      ST_IDLE: begin
        w.take   = 1'b1;
        w.cond   = COND_NO_IN;
        w.target = ST_IDLE;
      end
      ST_CHK: begin
        w.cond   = COND_NOT_READY;
        w.target = ST_EMIT;
      end
      ST_LOOP: begin
        w.run    = 1'b1;
        w.cond   = COND_BUSY;
        w.target = ST_LOOP;
      end
      ST_SDIFF: w.sdiff     = 1'b1;
      ST_SQR:   w.sqr       = 1'b1;
      ST_LHS:   w.scale_lhs = 1'b1;
      ST_RHS:   w.scale_rhs = 1'b1;
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_FULL;
        w.target = ST_EMIT;
      end
    endcase
    return w;
  endfunction

  // magnitude of a difference of two samples; never exceeds 2^24-1
  function automatic logic [SAMPLE_W-1:0] mag_diff(input logic [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] a;
    a = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
    return a[SAMPLE_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ptd_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_sequencer
// Step counter over the control store, with conditional jumps on status.
// ----------------------------------------------------------------------------
module ptd_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptd_pkg::stat_t  stat_i,
  output ptd_pkg::ctrl_t  ctrl_o
);
  import ptd_pkg::*;

  step_t pc_q, pc_d;
  ctrl_t cw;
  logic  taken;

  assign cw     = mc_rom(pc_q);
  assign ctrl_o = cw;

  always_comb begin
    unique case (cw.cond)
      COND_NEXT:      taken = 1'b0;
      COND_NO_IN:     taken = !stat_i.in_fire;
      COND_NOT_READY: taken = !stat_i.ready;
      COND_BUSY:      taken = stat_i.busy;
      COND_OUT_FULL:  taken = stat_i.out_full;
      default:        taken = 1'b0;
    endcase
    pc_d = taken ? cw.target : pc_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ptd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_datapath
// Sample ring, difference / square / accumulate pipeline, scale multiplier
// and the final trend compare.
// ----------------------------------------------------------------------------
module ptd_datapath #(
  parameter int WINDOW_DEPTH = 10,
  parameter int MIN_FILL     = 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ptd_pkg::ctrl_t                        ctrl_i,
  input  logic                                  in_fire_i,
  input  logic signed [ptd_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic signed [ptd_pkg::SAMPLE_W-1:0]   ref_level_i,
  input  logic        [ptd_pkg::OFFSET_W-1:0]   min_offset_i,
  output logic                                  busy_o,
  output logic                                  ready_o,
  output ptd_pkg::res_t                         res_o
);
  import ptd_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int DW = AW;
  localparam int QW = SQ_W + DW;
  localparam int CW = QW + 2 * DW;
  localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW_DEPTH - 1);
  localparam logic [FW-1:0] FULL     = FW'(WINDOW_DEPTH);

  logic [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  logic [AW-1:0]   wp_q, rp_q, wp_next, rp_next;
  logic [FW-1:0]   fill_q, rd_left_q, fill_next;
  logic            ready_q, have_prev_q, rv_q, mv_q, pv_q;
  logic [DW-1:0]   d_q;
  logic [2*DW-1:0] d2_q;

  logic [SAMPLE_W-1:0] prev_q, first_q, mag_q;
  logic [SQ_W-1:0]     prod_q, sq_p;
  logic [QW-1:0]       q_acc_q;
  logic                s_neg_q, s_zero_q, off_ok_q;
  logic [CW-1:0]       lhs_q, rhs_q, sc_p;

  logic              issue, trend_ok;
  logic [DIFF_W-1:0] diff, s_diff, off_diff;
  logic [DW:0]       kfac;
  logic [QW-1:0]     sc_a;
  logic [2*DW-1:0]   sc_b;

  assign fill_next = (fill_q == FULL) ? FULL : fill_q + FW'(1);
  assign wp_next   = (wp_q == LAST_PTR) ? '0 : wp_q + AW'(1);
  assign rp_next   = (rp_q == LAST_PTR) ? '0 : rp_q + AW'(1);
  assign issue     = ctrl_i.run && (rd_left_q != '0);

  assign diff     = {rdata_q[SAMPLE_W-1], rdata_q} - {prev_q[SAMPLE_W-1], prev_q};
  assign s_diff   = {prev_q[SAMPLE_W-1], prev_q} - {first_q[SAMPLE_W-1], first_q};
  assign off_diff = {ref_level_i[SAMPLE_W-1], ref_level_i}
                  - {first_q[SAMPLE_W-1], first_q};

  assign sq_p = SQ_W'(mag_q) * SQ_W'(mag_q);

  // shared scale multiplier: S^2 * (2d-1), then Q * d^2
  assign kfac = {d_q, 1'b0} - (DW + 1)'(1);
  assign sc_a = ctrl_i.scale_rhs ? q_acc_q : QW'(prod_q);
  assign sc_b = ctrl_i.scale_rhs ? d2_q : (2 * DW)'(kfac);
  assign sc_p = CW'(sc_a) * CW'(sc_b);

  // ring buffer, read data registered
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      mem[wp_q] <= sample_i;
    end
    if (issue) begin
      rdata_q <= mem[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      rd_left_q   <= '0;
      ready_q     <= 1'b0;
      have_prev_q <= 1'b0;
      rv_q        <= 1'b0;
      mv_q        <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      if (in_fire_i) begin
        wp_q        <= wp_next;
        fill_q      <= fill_next;
        rd_left_q   <= fill_next;
        // oldest entry: slot zero while filling, else the next write slot
        rp_q        <= (fill_next == FULL) ? wp_next : '0;
        ready_q     <= int'(fill_next) >= MIN_FILL;
        have_prev_q <= 1'b0;
      end else begin
        if (issue) begin
          rp_q      <= rp_next;
          rd_left_q <= rd_left_q - FW'(1);
        end
        if (ctrl_i.run && rv_q) begin
          have_prev_q <= 1'b1;
        end
      end
      rv_q <= issue;
      mv_q <= ctrl_i.run && rv_q && have_prev_q;
      pv_q <= ctrl_i.run && mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      d_q     <= DW'(fill_next - FW'(1));
      q_acc_q <= '0;
    end
    if (ctrl_i.run && rv_q) begin
      prev_q <= rdata_q;
      if (!have_prev_q) begin
        first_q <= rdata_q;
      end else begin
        mag_q <= mag_diff(diff);
      end
    end
    if (ctrl_i.run && mv_q) begin
      prod_q <= sq_p;
    end
    if (ctrl_i.run && pv_q) begin
      q_acc_q <= q_acc_q + QW'(prod_q);
    end
    if (ctrl_i.sdiff) begin
      mag_q    <= mag_diff(s_diff);
      s_neg_q  <= s_diff[DIFF_W-1];
      s_zero_q <= (s_diff == '0);
      off_ok_q <= mag_diff(off_diff) > SAMPLE_W'(min_offset_i);
      d2_q     <= (2 * DW)'(d_q) * (2 * DW)'(d_q);
    end
    if (ctrl_i.sqr) begin
      prod_q <= sq_p;
    end
    if (ctrl_i.scale_lhs) begin
      lhs_q <= sc_p;
    end
    if (ctrl_i.scale_rhs) begin
      rhs_q <= sc_p;
    end
  end

  // mean beyond deviation  <=>  Q*d^2 < S^2*(2d-1), with S nonzero
  assign trend_ok = rhs_q < lhs_q;

  assign busy_o  = (rd_left_q != '0) || rv_q || mv_q || pv_q;
  assign ready_o = ready_q;

  assign res_o.window_ready = ready_q;
  assign res_o.apogee = ready_q && !s_zero_q && off_ok_q && trend_ok && !s_neg_q;
  assign res_o.launch = ready_q && !s_zero_q && off_ok_q && trend_ok && s_neg_q;

endmodule
`default_nettype wire

FILE: rtl/pressure_trend_event_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Pressure trend event detector. Each accepted beat carries one signed 24-bit
// pressure sample; each sample yields one result beat with window_ready,
// apogee_detected and launch_detected. The newest WINDOW_DEPTH samples sit in
// a ring buffer; a microcoded sequencer walks them oldest to newest through a
// difference / square / accumulate pipeline, then runs the exact trend test
// on one shared scale multiplier. The ring buffer read port walks the held
// samples one entry per cycle; while fewer than MIN_FILL samples are held the
// walk and trend test are skipped. A new sample is taken while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
// pressure_trend_event_detector
// Top level: stream ports, configuration registers, output register.
// ----------------------------------------------------------------------------
module pressure_trend_event_detector #(
  parameter int WINDOW_DEPTH = 10,
  parameter int MIN_FILL     = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [23:0] sample
  input  logic [ptd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] window_ready, [1] apogee_detected, [2] launch_detected, [7:3] zero
  output logic [ptd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ptd_pkg::CFG_W-1:0]           cfg_data_i
);
  import ptd_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  res_t  res, out_res_q;
  logic  out_valid_q;
  logic  in_fire, busy, ready;

  logic signed [SAMPLE_W-1:0] ref_level_q;
  logic        [OFFSET_W-1:0] min_offset_q;

  assign s_axis_tready = ctrl.take;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign stat.in_fire  = in_fire;
  assign stat.ready    = ready;
  assign stat.busy     = busy;
  assign stat.out_full = out_valid_q && !m_axis_tready;

  ptd_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  ptd_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MIN_FILL     (MIN_FILL)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_fire_i    (in_fire),
    .sample_i     (s_axis_tdata[SAMPLE_W-1:0]),
    .ref_level_i  (ref_level_q),
    .min_offset_i (min_offset_q),
    .busy_o       (busy),
    .ready_o      (ready),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_level_q  <= REF_LEVEL_RESET;
      min_offset_q <= MIN_OFFSET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REFERENCE_LEVEL: ref_level_q  <= cfg_data_i[SAMPLE_W-1:0];
        REG_MIN_OFFSET:      min_offset_q <= cfg_data_i[OFFSET_W-1:0];
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit && !stat.out_full) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && !stat.out_full) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {OUT_PAD_W'(0), out_res_q.launch, out_res_q.apogee,
                          out_res_q.window_ready};

endmodule
`default_nettype wire

FILE: rtl/ptd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the pressure trend event detector, bound to the top.
// ----------------------------------------------------------------------------
module ptd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ptd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import ptd_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // one sample at a time: ready drops after each accepted beat
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("apogee and launch flagged together");

  a_flag_needs_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1] || m_axis_tdata[2]) |-> m_axis_tdata[0])
    else $error("event flagged before window ready");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:3] == '0)
    else $error("result padding bits not zero");

endmodule

bind pressure_trend_event_detector ptd_checker u_ptd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: tb/sv/ptd_trend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptd_trend_checker
// Watches the sample, flag and control ports of the pressure trend event
// detector, keeps its own copy of the sample window and the two registers,
// predicts the flags of every accepted sample and compares each flag beat,
// in order, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ptd_trend_checker #(
  parameter int WINDOW_DEPTH = 10,
  parameter int MIN_FILL     = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // [23:0] sample
  input  logic [ptd_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // [0] window_ready, [1] apogee_detected, [2] launch_detected, [7:3] zero
  input  logic [ptd_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                            cfg_we_i,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ptd_pkg::CFG_W-1:0]       cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import ptd_pkg::*;

  logic signed [SAMPLE_W-1:0] win_q [WINDOW_DEPTH];
  int                         held;
  logic signed [SAMPLE_W-1:0] ref_lvl;
  logic [OFFSET_W-1:0]        min_off;
  res_t                       flags_q [$];
  res_t                       got;
  res_t                       want;
  res_t                       pred;
  int                         fails;

  // pushes one sample into the window and works out the flags it raises
  function automatic res_t advance_window(input logic signed [SAMPLE_W-1:0] smp);
    res_t   r;
    longint sum_d;
    longint sq_sum;
    longint step;
    longint dev;
    longint lhs;
    int     k;
    int     nd;
    r = '0;
    if (held == WINDOW_DEPTH) begin
      for (k = 0; k < WINDOW_DEPTH - 1; k++) win_q[k] = win_q[k+1];
      win_q[WINDOW_DEPTH-1] = smp;
    end else begin
      win_q[held] = smp;
      held++;
    end
    if (held < MIN_FILL || held < 3) return r;
    r.window_ready = 1'b1;
    nd     = held - 1;
    sq_sum = 0;
    for (k = 1; k < held; k++) begin
      step   = longint'(win_q[k]) - longint'(win_q[k-1]);
      sq_sum += step * step;
    end
    sum_d = longint'(win_q[held-1]) - longint'(win_q[0]);
    dev   = longint'(ref_lvl) - longint'(win_q[0]);
    if (dev < 0) dev = -dev;
    // flat run, or oldest sample too close to the reference: no event
    if (sum_d == 0 || dev <= longint'(min_off)) return r;
    // mean beyond one deviation, squared out: S^2 (2d-1) > d^2 Q
    lhs = sum_d * sum_d * longint'(2 * nd - 1);
    if (lhs > longint'(nd) * longint'(nd) * sq_sum) begin
      if (sum_d > 0) r.apogee = 1'b1;
      else r.launch = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held    = 0;
      ref_lvl = REF_LEVEL_RESET;
      min_off = MIN_OFFSET_RESET;
      fails   = 0;
      flags_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_REFERENCE_LEVEL: ref_lvl = cfg_data_i[SAMPLE_W-1:0];
          REG_MIN_OFFSET:      min_off = cfg_data_i[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i[2:0]);
        if (flags_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("flag beat with no sample waiting: tdata=%b", m_tdata_i);
        end else begin
          want = flags_q.pop_front();
          if (got.window_ready !== want.window_ready || got.apogee !== want.apogee ||
              got.launch !== want.launch || m_tdata_i[OUT_TDATA_W-1:3] !== '0) begin
            fails++;
            if (fails <= 10)
              $display("flag mismatch: ready %b/%b apogee %b/%b launch %b/%b pad %b (exp/got)",
                       want.window_ready, got.window_ready, want.apogee, got.apogee,
                       want.launch, got.launch, m_tdata_i[OUT_TDATA_W-1:3]);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pred = advance_window(s_tdata_i[SAMPLE_W-1:0]);
        flags_q.insert(flags_q.size(), pred);
      end
      fail_count_o <= fails;
      pending_o    <= flags_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the pressure trend event detector with directed samples and with
// random rising, falling, flat and noisy runs under several register
// settings, stalls both streams at random and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ptd_pkg::*;

  localparam int DEPTH      = 10;
  localparam int FILL       = 5;
  localparam int PHASE_LEN  = 295;
  localparam int LONG_HOLD  = 300;
  localparam int QUIET_MAX  = 2000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  int                     fail_count;
  int                     pending;
  int                     hold_asked;
  int                     hold_served;
  int                     quiet;
  logic                   src_burst;
  logic                   snk_burst;

  pressure_trend_event_detector #(
    .WINDOW_DEPTH(DEPTH),
    .MIN_FILL    (FILL)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  ptd_trend_checker #(
    .WINDOW_DEPTH(DEPTH),
    .MIN_FILL    (FILL)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int src_gap();
    if (src_burst || $urandom_range(0, 99) < 60) return 0;
    return gap_len();
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input longint v);
    longint c;
    c = v;
    if (c > 64'sd8388607) c = 64'sd8388607;
    if (c < -64'sd8388608) c = -64'sd8388608;
    return c[SAMPLE_W-1:0];
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_flags();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // one run of samples: a ramp with noise, a flat stretch or plain noise
  task automatic send_trend_run(input logic signed [SAMPLE_W-1:0] ref_lvl,
                                input logic [OFFSET_W-1:0] off, inout int sent);
    int     kind;
    int     len;
    int     k;
    longint base;
    longint slope;
    longint amp;
    longint noise;
    logic [SAMPLE_W-1:0] v;
    kind      = $urandom_range(0, 9);
    len       = $urandom_range(10, 20);
    src_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1)) begin
      v    = SAMPLE_W'($urandom());
      base = longint'($signed(v));
    end else begin
      base = longint'(ref_lvl) + longint'(off) + longint'($urandom_range(1, 200000));
      if ($urandom_range(0, 1)) base = 2 * longint'(ref_lvl) - base;
    end
    slope = longint'($urandom_range(1, 1 << $urandom_range(0, 16)));
    if ($urandom_range(0, 1)) slope = -slope;
    amp = (slope < 0 ? -slope : slope) * longint'($urandom_range(0, 3)) / 2;
    if (kind == 9) begin
      slope = 0;
      amp   = $urandom_range(0, 1) ? 0 : longint'($urandom_range(0, 3));
    end
    for (k = 0; k < len; k++) begin
      if (kind < 2) begin
        v = SAMPLE_W'($urandom());
      end else begin
        noise = (amp > 0) ? longint'($urandom_range(0, int'(2 * amp))) - amp : 0;
        v     = clamp_sample(base + slope * k + noise);
      end
      send_sample(v, src_gap());
      sent++;
    end
  endtask

  // receiver: random stalls, bursts with none, and the requested long hold-off
  initial begin : flag_sink
    int idle_left;
    idle_left     = 0;
    snk_burst     = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) snk_burst = ~snk_burst;
      if (hold_served != hold_asked) begin
        hold_served++;
        idle_left = LONG_HOLD;
      end
      if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else if (snk_burst || $urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        idle_left = gap_len() - 1;
      end
    end
  end

  initial begin : watchdog
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int                         ph;
    int                         k;
    int                         sent;
    logic                       hold_done;
    logic signed [SAMPLE_W-1:0] ref_lvl;
    logic [OFFSET_W-1:0]        off;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_REFERENCE_LEVEL;
    cfg_data_i    = '0;
    hold_asked    = 0;
    hold_served   = 0;
    src_burst     = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: steady rise, fall, field extremes, then a flat stretch
    for (k = 0; k < 6; k++) send_sample(clamp_sample(1000 * (k + 1)), src_gap());
    for (k = 0; k < 6; k++) send_sample(clamp_sample(9000 - 1500 * k), src_gap());
    send_sample(24'h7FFFFF, src_gap());
    send_sample(24'h800000, src_gap());
    send_sample(24'h7FFFFF, src_gap());
    send_sample(24'h800000, src_gap());
    for (k = 0; k < 10; k++) send_sample(clamp_sample(-4000), src_gap());
    drain_flags();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          ref_lvl = 24'h800000;
          off     = '0;
        end
        1: begin
          ref_lvl = 24'h7FFFFF;
          off     = 23'h7FFFFF;
        end
        2: begin
          ref_lvl = SAMPLE_W'($urandom());
          off     = OFFSET_W'($urandom_range(0, 1000));
        end
        3: begin
          ref_lvl = '0;
          off     = '0;
        end
        4: begin
          ref_lvl = SAMPLE_W'($urandom());
          off     = OFFSET_W'($urandom_range(0, 1 << 20));
        end
        default: begin
          ref_lvl = clamp_sample($urandom_range(0, 200000));
          off     = OFFSET_W'($urandom_range(0, 5000));
        end
      endcase
      write_cfg(REG_REFERENCE_LEVEL, ref_lvl);
      write_cfg(REG_MIN_OFFSET, {1'($urandom_range(0, 1)), off});
      sent      = 0;
      hold_done = 1'b0;
      while (sent < PHASE_LEN) begin
        // receiver holds off while samples keep coming, so the input backs up
        if ((ph == 1 || ph == 4) && !hold_done && sent >= 40) begin
          hold_asked++;
          hold_done = 1'b1;
        end
        send_trend_run(ref_lvl, off, sent);
      end
      drain_flags();
    end

    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ptd_pkg.sv
rtl/ptd_sequencer.sv
rtl/ptd_datapath.sv
rtl/pressure_trend_event_detector.sv
rtl/ptd_checker.sv
tb/sv/ptd_trend_checker.sv
tb/sv/tb_top.sv
